FILE: src/odps_pkg.sv
package odps_pkg;

    localparam int DELAY_DEPTH_DEF = 4096;
    localparam int SAMPLE_BITS_DEF = 24;
    localparam int WINDOW_MIN      = 64;
    localparam int UNITY_Q16       = 65536;

    localparam logic [1:0] REG_WINDOW = 2'd0;
    localparam logic [1:0] REG_GAIN   = 2'd1;
    localparam logic [1:0] REG_LPF    = 2'd2;
    localparam logic [1:0] REG_MIX    = 2'd3;

    typedef struct packed {
        logic signed [23:0] left_in;
        logic signed [23:0] right_in;
    } in_item_t;

    typedef struct packed {
        logic signed [23:0] left_out;
        logic signed [23:0] right_out;
    } out_item_t;

endpackage

FILE: src/octave_down_pitch_shifter.sv
// Items pass through the sequencer one at a time: setup, delay line reads, then bit-serial
// multiplies per channel (wet, lowpass, mix); a new item is taken only once the last is done.
// Wet and mix each sum two products onto one accumulator; lowpass uses one product.
// A result waiting at the output does not block the next item; that item holds in its last cycle.
// Reset: a clearing pass sweeps both delay lines to zero;
// no item is accepted during it, configuration writes are taken throughout.
module octave_down_pitch_shifter
    import odps_pkg::*;
#(
    parameter int DELAY_DEPTH = DELAY_DEPTH_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  in_item_t         in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output out_item_t        out_data,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [1:0]       cfg_index,
    input  logic [16:0]      cfg_data
);
    localparam int AW = $clog2(DELAY_DEPTH);
    localparam int CW = AW + 1;
    localparam int GW = CW + 11;

    localparam logic [3:0] ST_CLEAR = 4'd0;
    localparam logic [3:0] ST_IDLE  = 4'd1;
    localparam logic [3:0] ST_PREP  = 4'd2;
    localparam logic [3:0] ST_WRITE = 4'd3;
    localparam logic [3:0] ST_READ  = 4'd4;
    localparam logic [3:0] ST_WET   = 4'd5;
    localparam logic [3:0] ST_LPF   = 4'd6;
    localparam logic [3:0] ST_MIX   = 4'd7;
    localparam logic [3:0] ST_DONE  = 4'd8;

    logic [3:0]  state_reg, state_next;
    logic [11:0] win_reg;
    logic [10:0] gstep_reg;
    logic [15:0] lpc_reg;
    logic [16:0] mix_reg;
    logic [AW-1:0] wp_reg, ph_reg;
    logic signed [31:0] lps_reg [2];
    logic [CW-1:0] clr_reg;

    logic signed [23:0] mem_l [DELAY_DEPTH];
    logic signed [23:0] mem_r [DELAY_DEPTH];
    logic signed [23:0] rd_l_reg, rd_r_reg;

    in_item_t in_reg;
    out_item_t res_reg;
    out_item_t mixed_reg;
    logic out_valid_reg;
    logic res_free;

    // per frame working values
    logic [CW-1:0] len_reg, w_reg;
    logic [16:0] g1_reg;
    logic [16:0] mixc_reg;
    logic [2:0]  rd_cnt_reg;
    logic [AW-1:0] rd_addr;
    logic signed [25:0] tap_reg [2][4];
    logic signed [31:0] wet_reg [2];
    logic ch_reg;
    logic [1:0] sub_reg;

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = res_reg;
    // output register can take the finished item this cycle
    assign res_free  = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            win_reg   <= 12'd1024;
            gstep_reg <= 11'd64;
            lpc_reg   <= 16'd16384;
            mix_reg   <= 17'd32768;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_WINDOW: win_reg   <= cfg_data[11:0];
                REG_GAIN:   gstep_reg <= cfg_data[10:0];
                REG_LPF:    lpc_reg   <= cfg_data[15:0];
                REG_MIX:    mix_reg   <= cfg_data;
            endcase
        end
    end

    // clamped window, derived combinationally from the register
    logic [CW-1:0] wcl;
    always_comb begin
        if (win_reg < 12'(WINDOW_MIN))
            wcl = CW'(WINDOW_MIN);
        else if (32'(win_reg) > 32'(DELAY_DEPTH / 2))
            wcl = CW'(DELAY_DEPTH / 2);
        else
            wcl = CW'(win_reg);
    end

    // tap address: tap k (0,1) sample j (0 = newer i1, 1 = older i0)
    logic [CW-1:0] h_sel, d_sel, i1, i0;
    always_comb begin
        h_sel = CW'(ph_reg);
        if (rd_cnt_reg[1]) begin
            h_sel = CW'(ph_reg) + w_reg;
            if (h_sel >= len_reg) h_sel = h_sel - len_reg;
        end
        d_sel = h_sel >> 1;
        i1 = CW'(wp_reg) + len_reg - d_sel;
        if (i1 >= len_reg) i1 = i1 - len_reg;
        i0 = (i1 == '0) ? len_reg - 1'b1 : i1 - 1'b1;
        if (rd_cnt_reg[0] && h_sel[0]) rd_addr = i0[AW-1:0];
        else                           rd_addr = i1[AW-1:0];
    end

    // serial multiply: 17 bit unsigned coefficient times signed value, 1 bit a cycle
    logic [4:0]  bit_reg;
    logic signed [63:0] acc_reg;
    logic signed [47:0] mcand_reg;
    logic [16:0] mplier_reg;
    logic signed [63:0] acc_next;
    always_comb begin
        acc_next = acc_reg;
        if (mplier_reg[0])
            acc_next = acc_reg + (64'(mcand_reg) <<< bit_reg);
    end

    logic signed [63:0] lpd, lpn;
    logic signed [31:0] s_cur;
    always_comb begin
        s_cur = lps_reg[ch_reg];
        lpd = 64'(wet_reg[ch_reg]) - 64'(s_cur);
        lpn = 64'(s_cur) + ((acc_reg + 64'sd32768) >>> 16);
    end

    logic signed [31:0] lp_sat;
    always_comb begin
        if (lpn > 64'sd2147483647)       lp_sat = 32'sh7fffffff;
        else if (lpn < -64'sd2147483648) lp_sat = 32'sh80000000;
        else                             lp_sat = lpn[31:0];
    end

    always_ff @(posedge clk) begin
        if (state_reg == ST_CLEAR) begin
            mem_l[clr_reg[AW-1:0]] <= '0;
            mem_r[clr_reg[AW-1:0]] <= '0;
        end else if (state_reg == ST_WRITE) begin
            mem_l[wp_reg] <= in_reg.left_in;
            mem_r[wp_reg] <= in_reg.right_in;
        end
        rd_l_reg <= mem_l[rd_addr];
        rd_r_reg <= mem_r[rd_addr];
    end

    // distance of the phase from the window center, times the gain slope
    logic [CW-1:0] ph_dev;
    logic [GW-1:0] g1_drop;
    always_comb begin
        if (CW'(ph_reg) >= w_reg) ph_dev = CW'(ph_reg) - w_reg;
        else                      ph_dev = w_reg - CW'(ph_reg);
        g1_drop = GW'(ph_dev) * GW'(gstep_reg);
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: if (clr_reg == CW'(DELAY_DEPTH - 1)) state_next = ST_IDLE;
            ST_IDLE:  if (in_valid && in_ready) state_next = ST_PREP;
            ST_PREP:  state_next = ST_WRITE;
            ST_WRITE: state_next = ST_READ;
            ST_READ:  if (rd_cnt_reg == 3'd4) state_next = ST_WET;
            ST_WET:   if (bit_reg == 5'd16 && sub_reg == 2'd2) state_next = ST_LPF;
            ST_LPF:   if (bit_reg == 5'd16) state_next = ST_MIX;
            ST_MIX:
                if (bit_reg == 5'd16 && sub_reg == 2'd2)
                    state_next = ch_reg ? ST_DONE : ST_WET;
            ST_DONE:  if (res_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // twice the interpolated value of tap k for the current channel
    function automatic logic signed [25:0] tapv(input logic k);
        logic signed [25:0] a, b;
        logic [CW-1:0] h;
        begin
            a = tap_reg[ch_reg][{k, 1'b0}];
            b = tap_reg[ch_reg][{k, 1'b1}];
            h = CW'(ph_reg);
            if (k) begin
                h = CW'(ph_reg) + w_reg;
                if (h >= len_reg) h = h - len_reg;
            end
            tapv = h[0] ? a + b : a <<< 1;
        end
    endfunction

    function automatic logic signed [23:0] in_ch();
        in_ch = ch_reg ? in_reg.right_in : in_reg.left_in;
    endfunction

    function automatic logic signed [23:0] sat_out(input logic signed [63:0] v);
        logic signed [63:0] r;
        begin
            r = (v + (64'sd1 <<< 23)) >>> 24;
            if (r > 64'sd8388607)       sat_out = 24'sh7fffff;
            else if (r < -64'sd8388608) sat_out = 24'sh800000;
            else                        sat_out = r[23:0];
        end
    endfunction

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            wp_reg        <= '0;
            ph_reg        <= '0;
            lps_reg[0]    <= '0;
            lps_reg[1]    <= '0;
            out_valid_reg <= 1'b0;
            rd_cnt_reg    <= '0;
            bit_reg       <= '0;
            ch_reg        <= 1'b0;
            sub_reg       <= '0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_DONE && res_free) out_valid_reg <= 1'b1;
            else if (out_ready)                   out_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_CLEAR: clr_reg <= clr_reg + 1'b1;
                ST_IDLE: begin
                    if (in_valid && in_ready) in_reg <= in_data;
                end
                ST_PREP: begin
                    len_reg <= wcl << 1;
                    w_reg   <= wcl;
                    if (CW'(wp_reg) >= (wcl << 1)) wp_reg <= '0;
                    if (CW'(ph_reg) >= (wcl << 1)) ph_reg <= '0;
                    mixc_reg <= (mix_reg > 17'd65536) ? 17'd65536 : mix_reg;
                    rd_cnt_reg <= '0;
                end
                ST_WRITE: begin
                    // ph_reg now valid; compute gain
                    if (g1_drop >= GW'(UNITY_Q16)) g1_reg <= '0;
                    else                           g1_reg <= 17'(UNITY_Q16) - g1_drop[16:0];
                end
                ST_READ: begin
                    // data of previous cycle's address arrives now
                    rd_cnt_reg <= rd_cnt_reg + 1'b1;
                    if (rd_cnt_reg != 3'd0) begin
                        tap_reg[0][rd_cnt_reg[1:0] - 2'd1] <= 26'(rd_l_reg);
                        tap_reg[1][rd_cnt_reg[1:0] - 2'd1] <= 26'(rd_r_reg);
                    end
                    if (rd_cnt_reg == 3'd4) begin
                        ch_reg <= 1'b0; sub_reg <= '0; bit_reg <= '0;
                    end
                end
                ST_WET, ST_LPF, ST_MIX: begin
                    if (bit_reg == 5'd0 && sub_reg == 2'd0) begin
                        // load operands
                        acc_reg <= '0;
                        sub_reg <= 2'd1;
                        if (state_reg == ST_WET) begin
                            mplier_reg <= g1_reg;
                            mcand_reg  <= 48'(tapv(1'b0));
                        end else if (state_reg == ST_LPF) begin
                            mplier_reg <= {1'b0, lpc_reg};
                            mcand_reg  <= 48'(lpd);
                        end else begin
                            mplier_reg <= 17'd65536 - mixc_reg;
                            mcand_reg  <= 48'(in_ch()) <<< 8;
                        end
                    end else if (bit_reg != 5'd16) begin
                        acc_reg    <= acc_next;
                        mplier_reg <= mplier_reg >> 1;
                        bit_reg    <= bit_reg + 1'b1;
                    end else begin
                        acc_reg <= acc_next;
                        bit_reg <= '0;
                        if (sub_reg == 2'd1 && state_reg != ST_LPF) begin
                            // second product accumulates onto the first
                            sub_reg <= 2'd2;
                            if (state_reg == ST_WET) begin
                                mplier_reg <= 17'd65536 - g1_reg;
                                mcand_reg  <= 48'(tapv(1'b1));
                            end else begin
                                mplier_reg <= mixc_reg;
                                mcand_reg  <= 48'(lps_reg[ch_reg]);
                            end
                        end else begin
                            sub_reg <= 2'd0;
                            if (state_reg == ST_WET)
                                wet_reg[ch_reg] <= 32'((acc_next + 64'sd256) >>> 9);
                            else if (state_reg == ST_LPF)
                                lps_reg[ch_reg] <= lp_sat;
                            else begin
                                if (ch_reg) mixed_reg.right_out <= sat_out(acc_next);
                                else        mixed_reg.left_out  <= sat_out(acc_next);
                                ch_reg <= ~ch_reg;
                            end
                        end
                    end
                end
                ST_DONE: begin
                    if (res_free) begin
                        res_reg <= mixed_reg;
                        wp_reg <= (CW'(wp_reg) + 1'b1 >= len_reg) ? '0 : wp_reg + 1'b1;
                        ph_reg <= (CW'(ph_reg) + 1'b1 >= len_reg) ? '0 : ph_reg + 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    logic unused_ok;
    assign unused_ok = ^{i0[CW-1], i1[CW-1], d_sel[0]};

    a_no_accept_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> !in_ready)
        else $error("accept during clear");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
        else $error("result dropped");
    a_ready_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("second item taken while busy");
endmodule

FILE: test/octave_down_pitch_shifter_test.sv
`timescale 1ns / 100ps

module octave_down_pitch_shifter_test;
    import odps_pkg::*;

    localparam int  LINE_DEPTH   = 4096;
    localparam int  SETTLE_WAIT  = 40;
    localparam longint CYCLE_LIMIT = 2000000; // clearing pass + ~1100 items, slow

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_ready;
    in_item_t  in_data = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    out_item_t out_data;
    logic      cfg_valid = 1'b0;
    logic      cfg_ready;
    logic [1:0]  cfg_index = REG_WINDOW;
    logic [16:0] cfg_data = '0;

    octave_down_pitch_shifter DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Shadow copy of the shifter: registers as written, delay lines,
    // pointers and the per-channel lowpass state.
    // ------------------------------------------------------------------
    longint window_reg = 1024;
    longint gain_reg   = 64;
    longint lpf_reg    = 16384;
    longint mix_reg    = 32768;

    longint delay_line [2][LINE_DEPTH];
    longint lowpass_acc [2];
    longint wr_ptr = 0;
    longint phase_half = 0;

    in_item_t  frames_pending [$];   // frames waiting for the driver
    out_item_t frames_expected [$];  // predicted outputs, oldest first

    int  errors = 0;
    int  frames_sent = 0;
    int  frames_checked = 0;
    longint cycles = 0;

    initial
    begin
        for (int c = 0; c < 2; c++)
        begin
            lowpass_acc[c] = 0;
            for (int i = 0; i < LINE_DEPTH; i++)
                delay_line[c][i] = 0;
        end
    end

    // twice the sample at half-sample delay h, interpolated on odd h
    function automatic longint tap_x2(int c, longint h, longint len);
        longint d, i0, i1;
        d  = h >> 1;
        i1 = wr_ptr + len - d;
        if (i1 >= len)
            i1 -= len;
        if (h[0])
        begin
            i0 = (i1 == 0) ? len - 1 : i1 - 1;
            return delay_line[c][i0] + delay_line[c][i1];
        end
        return 2 * delay_line[c][i1];
    endfunction

    function automatic logic signed [23:0] mix_channel(int c, longint dry, longint h2,
                                                       longint g1, longint len,
                                                       longint mix);
        longint wet, s, o;
        wet = tap_x2(c, phase_half, len) * g1 + tap_x2(c, h2, len) * (UNITY_Q16 - g1);
        wet = (wet + 256) >>> 9;
        s = lowpass_acc[c];
        s += (lpf_reg * (wet - s) + 32768) >>> 16;
        if (s > 64'sd2147483647)
            s = 64'sd2147483647;
        if (s < -64'sd2147483648)
            s = -64'sd2147483648;
        lowpass_acc[c] = s;
        o = (dry * 256 * (UNITY_Q16 - mix) + s * mix + (64'sd1 <<< 23)) >>> 24;
        if (o > 64'sd8388607)
            o = 64'sd8388607;
        if (o < -64'sd8388608)
            o = -64'sd8388608;
        return o[23:0];
    endfunction

    // one stereo frame through the shifter; advances the shadow state
    function automatic out_item_t shift_frame(in_item_t f);
        out_item_t r;
        longint w, len, h2, dl, dr, ph_dev, g1, mix;
        w = window_reg;
        if (w < WINDOW_MIN)
            w = WINDOW_MIN;
        if (w > LINE_DEPTH / 2)
            w = LINE_DEPTH / 2;
        len = 2 * w;
        // window shrank under the pointers
        if (wr_ptr >= len)
            wr_ptr = 0;
        if (phase_half >= len)
            phase_half = 0;
        dl = longint'(f.left_in);
        dr = longint'(f.right_in);
        // written before the taps are read: zero delay sees this frame
        delay_line[0][wr_ptr] = dl;
        delay_line[1][wr_ptr] = dr;
        h2 = phase_half + w;
        if (h2 >= len)
            h2 -= len;
        ph_dev = phase_half - w;
        if (ph_dev < 0)
            ph_dev = -ph_dev;
        g1 = UNITY_Q16 - ph_dev * gain_reg;
        if (g1 < 0)
            g1 = 0;
        if (g1 > UNITY_Q16)
            g1 = UNITY_Q16;
        mix = (mix_reg > UNITY_Q16) ? UNITY_Q16 : mix_reg;
        r.left_out  = mix_channel(0, dl, h2, g1, len, mix);
        r.right_out = mix_channel(1, dr, h2, g1, len, mix);
        wr_ptr++;
        if (wr_ptr >= len)
            wr_ptr = 0;
        phase_half++;
        if (phase_half >= len)
            phase_half = 0;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Sender: bursts of random length, random gaps between them.
    // ------------------------------------------------------------------
    int burst_left = 0;
    int gap_left = 0;

    always @(posedge clk)
    begin
        if (rst_n && (!in_valid || in_ready))
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                in_valid <= 1'b0;
            end
            else if (frames_pending.size() > 0)
            begin
                in_data  <= frames_pending.pop_front();
                in_valid <= 1'b1;
                if (burst_left > 0)
                    burst_left--;
                else
                begin
                    burst_left = $urandom_range(0, 12);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
                end
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Receiver: stall style is redrawn at random, periodically (none, random, periodic).
    int stall_mode = 0;

    always @(posedge clk)
    begin
        if (cycles % 128 == 0)
            stall_mode = $urandom_range(0, 2);
        case (stall_mode)
            0: out_ready <= 1'b1;
            1: out_ready <= 1'($urandom_range(0, 1));
            default: out_ready <= (cycles % 23) > 14;
        endcase
    end

    // Monitor: predicts on input accept, tracks register writes, checks outputs.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("%0t: timeout after %0d cycles", $time, cycles);
            $display("FAILED: results differ");
            $finish;
        end
        if (rst_n && cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_WINDOW: window_reg = longint'(cfg_data[11:0]);
                REG_GAIN:   gain_reg   = longint'(cfg_data[10:0]);
                REG_LPF:    lpf_reg    = longint'(cfg_data[15:0]);
                REG_MIX:    mix_reg    = longint'(cfg_data[16:0]);
            endcase
        end
        if (rst_n && in_valid && in_ready)
        begin
            frames_expected.push_back(shift_frame(in_data));
            frames_sent++;
        end
        if (rst_n && out_valid && out_ready)
        begin
            if (frames_expected.size() == 0)
            begin
                $display("%0t: unexpected output L=%0d R=%0d", $time,
                         out_data.left_out, out_data.right_out);
                errors++;
            end
            else
            begin
                out_item_t e;
                e = frames_expected.pop_front();
                if (out_data.left_out !== e.left_out)
                begin
                    $display("%0t: left_out expected %0d actual %0d", $time,
                             e.left_out, out_data.left_out);
                    errors++;
                end
                if (out_data.right_out !== e.right_out)
                begin
                    $display("%0t: right_out expected %0d actual %0d", $time,
                             e.right_out, out_data.right_out);
                    errors++;
                end
                frames_checked++;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    task automatic reg_write(logic [1:0] idx, logic [16:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain;
        while (frames_pending.size() > 0 || in_valid || frames_expected.size() > 0)
            @(posedge clk);
        repeat (SETTLE_WAIT) @(posedge clk);
    endtask

    task automatic queue_frame(logic [23:0] l, logic [23:0] r);
        in_item_t f;
        f.left_in  = l;
        f.right_in = r;
        frames_pending.push_back(f);
    endtask

    function automatic logic [23:0] rand_sample();
        case ($urandom_range(0, 9))
            0: return 24'h7FFFFF;
            1: return 24'h800000;
            2: return 24'($urandom_range(0, 255) - 128);
            default: return 24'($urandom());
        endcase
    endfunction

    // window, gain step, lowpass coeff, mix; covers clamped window, gain
    // too steep or too shallow, mix above unity, and a shrinking window
    int set_window [8] = '{64,   2048, 100,   0,      4095,  128,   70,    300};
    int set_gain   [8] = '{1024, 32,   655,   2047,   100,   512,   1,     218};
    int set_lpf    [8] = '{65535, 0,   30000, 1,      16384, 65535, 50000, 8000};
    int set_mix    [8] = '{65536, 0,   40000, 131071, 20000, 65536, 60000, 32768};

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // directed frames under reset settings: full scale, zero, alternation
        queue_frame(24'h7FFFFF, 24'h800000);
        queue_frame(24'h800000, 24'h7FFFFF);
        queue_frame(24'h000000, 24'h000000);
        queue_frame(24'hFFFFFF, 24'h000001);
        queue_frame(24'h555555, 24'hAAAAAA);
        queue_frame(24'hAAAAAA, 24'h555555);
        for (int i = 0; i < 8; i++)
            queue_frame(24'h7FFFFF, 24'h7FFFFF);
        for (int i = 0; i < 8; i++)
            queue_frame(24'h800000, 24'h800000);
        drain();

        for (int p = 0; p < 8; p++)
        begin
            reg_write(REG_WINDOW, 17'(set_window[p]));
            reg_write(REG_GAIN,   17'(set_gain[p]));
            reg_write(REG_LPF,    17'(set_lpf[p]));
            reg_write(REG_MIX,    17'(set_mix[p]));
            for (int i = 0; i < 135; i++)
                queue_frame(rand_sample(), rand_sample());
            drain();
        end

        $display("Ran %0d stereo frames through 9 register settings, %0d outputs checked,",
                 frames_sent, frames_checked);
        $display("with window, gain, lowpass and mix at their limits and beyond.");
        if (errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
